FILE: rtl/core/two_key_bucket_priority_queue_macros.svh
`ifndef TWO_KEY_BUCKET_PRIORITY_QUEUE_MACROS_SVH
`define TWO_KEY_BUCKET_PRIORITY_QUEUE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TKBPQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define TKBPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/tkbpq_pkg.sv
package tkbpq_pkg;

   localparam int F_LEVELS_DEF = 128;
   localparam int H_LEVELS_DEF = 64;
   localparam int CAPACITY_DEF = 1024;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;
   localparam logic [1:0] STATUS_FULL  = 2'd3;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH_RD,
      ST_PUSH_WR,
      ST_POP_RD,
      ST_POP_UPD,
      ST_ROW_RD,
      ST_ROW_FFS,
      ST_HEAD_RD,
      ST_HEAD_LD,
      ST_HANDLE_RD,
      ST_HANDLE_LD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic push_rd;
      logic push_wr;
      logic pop_rd;
      logic pop_upd;
      logic row_rd;
      logic row_ffs;
      logic head_rd;
      logic head_ld;
      logic handle_rd;
      logic handle_ld;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic req_pop;
      logic req_err;
      logic tail;
      logic row_left;
      logic any_left;
      logic none_held;
   } dp_status_type;

endpackage

FILE: rtl/core/tkbpq_ctrl.sv
module tkbpq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  tkbpq_pkg::dp_status_type dp_status,
   output tkbpq_pkg::dp_cmd_type    dp_cmd
);
   import tkbpq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (dp_status.req_err) state_in = ST_DONE;
               else if (dp_status.req_pop) state_in = ST_POP_RD;
               else state_in = ST_PUSH_RD;
            end
         end
         ST_PUSH_RD:   state_in = ST_PUSH_WR;
         ST_PUSH_WR:   state_in = ST_DONE;
         ST_POP_RD:    state_in = ST_POP_UPD;
         ST_POP_UPD: begin
            if (dp_status.none_held) state_in = ST_DONE;
            else if (!dp_status.tail) state_in = ST_HANDLE_RD;
            else if (dp_status.row_left) state_in = ST_HEAD_RD;
            else if (dp_status.any_left) state_in = ST_ROW_RD;
            else state_in = ST_DONE;
         end
         ST_ROW_RD:    state_in = ST_ROW_FFS;
         ST_ROW_FFS:   state_in = ST_HEAD_RD;
         ST_HEAD_RD:   state_in = ST_HEAD_LD;
         ST_HEAD_LD:   state_in = ST_HANDLE_RD;
         ST_HANDLE_RD: state_in = ST_HANDLE_LD;
         ST_HANDLE_LD: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd           = '0;
      dp_cmd.capture   = (state_ff == ST_IDLE) && req_valid;
      dp_cmd.push_rd   = (state_ff == ST_PUSH_RD);
      dp_cmd.push_wr   = (state_ff == ST_PUSH_WR);
      dp_cmd.pop_rd    = (state_ff == ST_POP_RD);
      dp_cmd.pop_upd   = (state_ff == ST_POP_UPD);
      dp_cmd.row_rd    = (state_ff == ST_ROW_RD);
      dp_cmd.row_ffs   = (state_ff == ST_ROW_FFS);
      dp_cmd.head_rd   = (state_ff == ST_HEAD_RD);
      dp_cmd.head_ld   = (state_ff == ST_HEAD_LD);
      dp_cmd.handle_rd = (state_ff == ST_HANDLE_RD);
      dp_cmd.handle_ld = (state_ff == ST_HANDLE_LD);
      dp_cmd.load_rsp  = (state_ff == ST_DONE) && rsp_free;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/core/tkbpq_datapath.sv
module tkbpq_datapath #(
   parameter int F_LEVELS = tkbpq_pkg::F_LEVELS_DEF,
   parameter int H_LEVELS = tkbpq_pkg::H_LEVELS_DEF,
   parameter int CAPACITY = tkbpq_pkg::CAPACITY_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tkbpq_pkg::dp_cmd_type    dp_cmd,
   output tkbpq_pkg::dp_status_type dp_status,
   input  logic                     req_type,
   input  logic [6:0]               req_g_cost,
   input  logic [5:0]               req_h_cost,
   input  logic [15:0]              req_handle,
   output logic [1:0]               rsp_status,
   output logic                     rsp_top_valid,
   output logic [15:0]              rsp_top_handle,
   output logic [7:0]               rsp_min_f,
   output logic [5:0]               rsp_min_h,
   output logic [10:0]              rsp_entry_count,
   output logic                     rsp_is_empty
);
   import tkbpq_pkg::*;
   `include "two_key_bucket_priority_queue_macros.svh"

   localparam int RW = (F_LEVELS > 1) ? $clog2(F_LEVELS) : 1;
   localparam int HW = (H_LEVELS > 1) ? $clog2(H_LEVELS) : 1;
   localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int NB = F_LEVELS * H_LEVELS;
   localparam int BW = $clog2(NB);

   // Occupancy: one bit per row of buckets in flip-flops, one word per row in memory.
   // A row whose summary bit is clear reads as all empty.
   logic [H_LEVELS-1:0] row_mem [F_LEVELS];
   logic [SW-1:0]       head_mem [NB];
   logic [SW:0]         link_mem [CAPACITY];
   logic [15:0]         handle_mem [CAPACITY];
   logic [SW-1:0]       free_mem [CAPACITY];

   logic [F_LEVELS-1:0] summary_ff, summary_in;
   logic [CW-1:0]       held_ff, held_in;
   logic [CW-1:0]       free_top_ff, free_top_in;
   logic [CW-1:0]       wmark_ff, wmark_in;
   logic [RW-1:0]       min_row_ff, min_row_in;
   logic [HW-1:0]       min_col_ff, min_col_in;
   logic [SW-1:0]       top_slot_ff;
   logic [15:0]         top_handle_ff;

   logic [RW-1:0]       req_row_ff;
   logic [HW-1:0]       req_col_ff;
   logic [15:0]         req_handle_ff;
   logic [1:0]          status_ff;

   logic [H_LEVELS-1:0] row_rdata_ff;
   logic                row_ok_ff;
   logic [SW-1:0]       head_rdata_ff;
   logic [SW:0]         link_rdata_ff;
   logic [15:0]         handle_rdata_ff;
   logic [SW-1:0]       free_rdata_ff;
   logic                fresh_ff;
   logic [SW-1:0]       free_idx_ff;

   logic [7:0]          f_sum;
   logic                range_bad;
   logic [1:0]          status_in;
   logic [CW-1:0]       free_dec;
   logic [H_LEVELS-1:0] row_data;
   logic [H_LEVELS-1:0] row_new;
   logic [F_LEVELS-1:0] summary_rest;
   logic [RW-1:0]       row_addr;
   logic [BW-1:0]       req_bucket;
   logic [BW-1:0]       min_bucket;
   logic [SW-1:0]       new_slot;
   logic                push_wins;

   function automatic logic [HW-1:0] ffs_row(input logic [H_LEVELS-1:0] v);
      logic [HW-1:0] r;
      r = '0;
      for (int i = H_LEVELS - 1; i >= 0; i--) begin
         if (v[i]) r = HW'(i);
      end
      return r;
   endfunction

   function automatic logic [RW-1:0] ffs_sum(input logic [F_LEVELS-1:0] v);
      logic [RW-1:0] r;
      r = '0;
      for (int i = F_LEVELS - 1; i >= 0; i--) begin
         if (v[i]) r = RW'(i);
      end
      return r;
   endfunction

   // Request decode.
   assign f_sum     = {1'b0, req_g_cost} + {2'b00, req_h_cost};
   assign range_bad = (int'(req_h_cost) >= H_LEVELS) || (int'(f_sum) >= F_LEVELS);

   always_comb begin
      status_in = STATUS_OK;
      if (req_type == REQ_POP) begin
         if (held_ff == '0) status_in = STATUS_EMPTY;
      end else if (range_bad) begin
         status_in = STATUS_RANGE;
      end else if (held_ff == CW'(CAPACITY)) begin
         status_in = STATUS_FULL;
      end
   end

   assign free_dec     = free_top_ff - CW'(1);
   assign row_data     = row_ok_ff ? row_rdata_ff : '0;
   assign row_new      = row_data & ~(H_LEVELS'(1) << min_col_ff);
   assign summary_rest = summary_ff & ~(F_LEVELS'(1) << min_row_ff);
   assign row_addr     = dp_cmd.push_rd ? req_row_ff : min_row_ff;
   assign req_bucket   = BW'(req_row_ff) * BW'(H_LEVELS) + BW'(req_col_ff);
   assign min_bucket   = BW'(min_row_ff) * BW'(H_LEVELS) + BW'(min_col_ff);
   assign new_slot     = fresh_ff ? free_idx_ff : free_rdata_ff;
   assign push_wins    = (held_ff == CW'(1)) || (req_row_ff < min_row_ff) ||
                         ((req_row_ff == min_row_ff) && (req_col_ff <= min_col_ff));

   assign dp_status.req_pop   = (req_type == REQ_POP);
   assign dp_status.req_err   = (status_in != STATUS_OK);
   assign dp_status.tail      = link_rdata_ff[SW];
   assign dp_status.row_left  = (row_new != '0);
   assign dp_status.any_left  = (summary_rest != '0);
   assign dp_status.none_held = (held_ff == '0);

   // Memory reads, registered.
   always_ff @(posedge clock) begin
      if (dp_cmd.push_rd || dp_cmd.pop_rd || dp_cmd.row_rd) begin
         row_rdata_ff <= row_mem[row_addr];
         row_ok_ff    <= summary_ff[row_addr];
      end
      if (dp_cmd.push_rd || dp_cmd.head_rd) begin
         head_rdata_ff <= head_mem[dp_cmd.push_rd ? req_bucket : min_bucket];
      end
      if (dp_cmd.pop_rd) link_rdata_ff <= link_mem[top_slot_ff];
      if (dp_cmd.handle_rd) handle_rdata_ff <= handle_mem[top_slot_ff];
      if (dp_cmd.push_rd) begin
         free_rdata_ff <= free_mem[free_dec[SW-1:0]];
         free_idx_ff   <= free_dec[SW-1:0];
         fresh_ff      <= (free_dec < wmark_ff);
      end
   end

   // Memory writes. The occupancy bit of a bucket only clears when its bottom entry leaves.
   always_ff @(posedge clock) begin
      if (dp_cmd.push_wr) begin
         row_mem[req_row_ff]  <= row_data | (H_LEVELS'(1) << req_col_ff);
         head_mem[req_bucket] <= new_slot;
         link_mem[new_slot]   <= {!row_data[req_col_ff], head_rdata_ff};
         handle_mem[new_slot] <= req_handle_ff;
      end
      if (dp_cmd.pop_upd) begin
         if (link_rdata_ff[SW]) row_mem[min_row_ff] <= row_new;
         else head_mem[min_bucket] <= link_rdata_ff[SW-1:0];
      end
      if (dp_cmd.pop_rd) free_mem[free_top_ff[SW-1:0]] <= top_slot_ff;
   end

   always_comb begin
      summary_in  = summary_ff;
      held_in     = held_ff;
      free_top_in = free_top_ff;
      wmark_in    = wmark_ff;
      min_row_in  = min_row_ff;
      min_col_in  = min_col_ff;
      if (dp_cmd.push_rd) begin
         held_in     = held_ff + CW'(1);
         free_top_in = free_dec;
         if (free_dec < wmark_ff) wmark_in = free_dec;
      end
      if (dp_cmd.push_wr) begin
         summary_in[req_row_ff] = 1'b1;
         if (push_wins) begin
            min_row_in = req_row_ff;
            min_col_in = req_col_ff;
         end
      end
      if (dp_cmd.pop_rd) begin
         held_in     = held_ff - CW'(1);
         free_top_in = free_top_ff + CW'(1);
      end
      if (dp_cmd.pop_upd && link_rdata_ff[SW]) begin
         summary_in[min_row_ff] = (row_new != '0);
         if (row_new != '0) min_col_in = ffs_row(row_new);
         else min_row_in = ffs_sum(summary_rest);
      end
      if (dp_cmd.row_ffs) min_col_in = ffs_row(row_data);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         summary_ff  <= '0;
         held_ff     <= '0;
         free_top_ff <= CW'(CAPACITY);
         wmark_ff    <= CW'(CAPACITY);
      end else begin
         summary_ff  <= summary_in;
         held_ff     <= held_in;
         free_top_ff <= free_top_in;
         wmark_ff    <= wmark_in;
      end
   end

   always_ff @(posedge clock) begin
      min_row_ff <= min_row_in;
      min_col_ff <= min_col_in;
      if (dp_cmd.capture) begin
         req_row_ff    <= RW'(f_sum);
         req_col_ff    <= HW'(req_h_cost);
         req_handle_ff <= req_handle;
         status_ff     <= status_in;
      end
      if (dp_cmd.push_wr && push_wins) begin
         top_slot_ff   <= new_slot;
         top_handle_ff <= req_handle_ff;
      end
      if (dp_cmd.pop_upd && !link_rdata_ff[SW]) top_slot_ff <= link_rdata_ff[SW-1:0];
      if (dp_cmd.head_ld) top_slot_ff <= head_rdata_ff;
      if (dp_cmd.handle_ld) top_handle_ff <= handle_rdata_ff;
      if (dp_cmd.load_rsp) begin
         rsp_status      <= status_ff;
         rsp_top_valid   <= (held_ff != '0);
         rsp_top_handle  <= (held_ff != '0) ? top_handle_ff : 16'd0;
         rsp_min_f       <= (held_ff != '0) ? 8'(min_row_ff) : 8'(F_LEVELS);
         rsp_min_h       <= (held_ff != '0) ? 6'(min_col_ff) : 6'd0;
         rsp_entry_count <= 11'(held_ff);
         rsp_is_empty    <= (held_ff == '0);
      end
   end

   `TKBPQ_ASSERT(a_slot_balance, clock, reset, (int'(held_ff) + int'(free_top_ff)) == CAPACITY, "held and free slots do not add up to capacity")
   `TKBPQ_ASSERT(a_summary_empty, clock, reset, !dp_cmd.load_rsp || ((held_ff == '0) == (summary_ff == '0)), "occupancy summary disagrees with entry count")
   `TKBPQ_ASSERT_NEXT(a_first_push_top, clock, reset, dp_cmd.push_wr && (held_ff == CW'(1)), top_handle_ff == $past(req_handle_ff), "push into empty queue did not become top")

endmodule

FILE: rtl/core/two_key_bucket_priority_queue.sv
// Bucket priority queue with (f, h) ordering and last-in-first-out ties. One request
// is in flight at a time and answers with one response word. A push walks PUSH_RD and
// PUSH_WR; a pop walks POP_RD and POP_UPD, ending there if the queue empties, adding
// HANDLE_RD and HANDLE_LD if the popped bucket still holds entries, HEAD_RD and HEAD_LD
// before those if the next bucket is in the same occupancy row, and ROW_RD and ROW_FFS
// before those if the next row comes from the row summary. Errors go straight to DONE.
// The sequencer walks registered reads of occupancy row, bucket head and entry handle.
module two_key_bucket_priority_queue #(
   parameter int F_LEVELS = tkbpq_pkg::F_LEVELS_DEF,
   parameter int H_LEVELS = tkbpq_pkg::H_LEVELS_DEF,
   parameter int CAPACITY = tkbpq_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [6:0]  req_g_cost,
   input  logic [5:0]  req_h_cost,
   input  logic [15:0] req_handle,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_top_valid,
   output logic [15:0] rsp_top_handle,
   output logic [7:0]  rsp_min_f,
   output logic [5:0]  rsp_min_h,
   output logic [10:0] rsp_entry_count,
   output logic        rsp_is_empty
);
   import tkbpq_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   tkbpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   tkbpq_datapath #(
      .F_LEVELS (F_LEVELS),
      .H_LEVELS (H_LEVELS),
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .dp_cmd          (dp_cmd),
      .dp_status       (dp_status),
      .req_type        (req_type),
      .req_g_cost      (req_g_cost),
      .req_h_cost      (req_h_cost),
      .req_handle      (req_handle),
      .rsp_status      (rsp_status),
      .rsp_top_valid   (rsp_top_valid),
      .rsp_top_handle  (rsp_top_handle),
      .rsp_min_f       (rsp_min_f),
      .rsp_min_h       (rsp_min_h),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

endmodule
